// File: src/beep_pattern_sequencer_top_defines.svh
// Assertion macros used by the checker file of the beep pattern sequencer.
`ifndef BEEP_PATTERN_SEQUENCER_TOP_DEFINES_SVH
`define BEEP_PATTERN_SEQUENCER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bps_pkg.sv
package bps_pkg;

    localparam int TUNE_BITS_DEF  = 32;
    localparam int TIME_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int OP_W     = 2;
    localparam int MODE_W   = 2;
    localparam int KIND_W   = 2;
    localparam int DUTY_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int M_TDATA_W  = 16;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_LED   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_COUNTED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FOLLOW  = 2'd2;

    localparam logic [KIND_W-1:0] DRIVE_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] DRIVE_DIGITAL = 2'd1;
    localparam logic [KIND_W-1:0] DRIVE_PWM     = 2'd2;
    localparam logic [KIND_W-1:0] DRIVE_RSVD    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_RANGE = 2'd2;

    localparam logic [DUTY_W-1:0] PWM_RANGE_RESET = 10'd1023;

endpackage

// File: src/beep_pattern_sequencer_top.sv
// Beep pattern sequencer.
// Each transfer on the slave channel is one event: s_tuser selects a start
// command, a tick or an LED event, and s_tdata carries the command fields.
// Every event yields exactly one transfer on the master channel: m_tuser
// says whether the pin, a PWM duty or nothing is written, and m_tdata holds
// the pin level, the duty and the busy flag after the event.
// An event moves from the input register to the result register once the
// result register is free or being taken, and its result is then offered
// on the master channel. A new event is taken every cycle while the master
// side keeps up; the whole step, including the tune bit search, is one pass
// of logic between the two registers.
// When the master side stalls, the result register holds and the input
// register fills; s_tready then drops until the result is taken.
// The cfg port writes invert_output, frequency_mode and pwm_full_range; the
// user must write it only while no event is in flight, and the block itself
// does not enforce this. Reset empties both registers, clears the sequencer
// state and returns the configuration to its defaults, and takes effect at
// the first clock edge with aresetn low.
module beep_pattern_sequencer_top
    import bps_pkg::*;
#(
    parameter int TUNE_BITS  = TUNE_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int S_FIELDS_W = COUNT_BITS + 2 * TIME_BITS + TUNE_BITS + MODE_W + 1,
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // beep_count, on_ticks, off_ticks, tune_pattern, repeat_mode, led_level
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // operation
    input  logic [OP_W-1:0]        s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // pin_level, pwm_duty, busy_res
    output logic [M_TDATA_W-1:0]   m_tdata,
    // drive_kind
    output logic [KIND_W-1:0]      m_tuser
);

    localparam int BL_W    = $clog2(TUNE_BITS + 1);
    localparam int TIDX_W  = $clog2(TUNE_BITS);
    localparam int PHASE_W = COUNT_BITS + 1;
    localparam int ON_LSB  = COUNT_BITS;
    localparam int OFF_LSB = ON_LSB + TIME_BITS;
    localparam int TUNE_LSB = OFF_LSB + TIME_BITS;
    localparam int MODE_LSB = TUNE_LSB + TUNE_BITS;
    localparam int LED_LSB  = MODE_LSB + MODE_W;
    localparam int PAD_W    = M_TDATA_W - DUTY_W - 2;

    logic                  invert_reg;
    logic                  freq_mode_reg;
    logic [DUTY_W-1:0]     pwm_range_reg;

    logic                  in_valid_reg;
    logic [S_TDATA_W-1:0]  in_data_reg;
    logic [OP_W-1:0]       in_op_reg;

    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic [KIND_W-1:0]     out_kind_reg;

    logic [TIME_BITS-1:0]  off_dur_reg, off_dur_next;
    logic [TIME_BITS-1:0]  on_dur_reg, on_dur_next;
    logic [TIME_BITS-1:0]  ticks_left_reg, ticks_left_next;
    logic [BL_W-1:0]       bits_left_reg, bits_left_next;
    logic [BL_W-1:0]       tune_len_reg, tune_len_next;
    logic [TUNE_BITS-1:0]  tune_reg, tune_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic                  enabled_reg, enabled_next;
    logic                  beep_level_reg, beep_level_next;
    logic                  last_pwm_reg, last_pwm_next;

    logic                  advance;
    logic [COUNT_BITS-1:0] f_count;
    logic [TIME_BITS-1:0]  f_on;
    logic [TIME_BITS-1:0]  f_off;
    logic [TUNE_BITS-1:0]  f_tune;
    logic [MODE_W-1:0]     f_mode;
    logic                  f_led;
    logic [BL_W-1:0]       tune_len_calc;
    logic [BL_W-1:0]       bits_dec;
    logic [TIME_BITS-1:0]  ticks_dec;
    logic [PHASE_W-1:0]    phase_step;
    logic                  do_drive;
    logic                  drive_level;
    logic                  out_level;
    logic [KIND_W-1:0]     res_kind;
    logic                  res_pin;
    logic [DUTY_W-1:0]     res_duty;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    assign f_count = in_data_reg[COUNT_BITS-1:0];
    assign f_on    = in_data_reg[ON_LSB +: TIME_BITS];
    assign f_off   = in_data_reg[OFF_LSB +: TIME_BITS];
    assign f_tune  = in_data_reg[TUNE_LSB +: TUNE_BITS];
    assign f_mode  = in_data_reg[MODE_LSB +: MODE_W];
    assign f_led   = in_data_reg[LED_LSB];

    always_comb begin
        tune_len_calc = '0;
        for (int i = 0; i < TUNE_BITS; i++) begin
            if (f_tune[i]) begin
                tune_len_calc = BL_W'(i + 1);
            end
        end
    end

    assign bits_dec   = bits_left_reg - BL_W'(1);
    assign ticks_dec  = ticks_left_reg - TIME_BITS'(1);
    assign phase_step = phase_reg - ((tune_len_reg != '0) ? PHASE_W'(2) : PHASE_W'(1));

    always_comb begin
        off_dur_next    = off_dur_reg;
        on_dur_next     = on_dur_reg;
        ticks_left_next = ticks_left_reg;
        bits_left_next  = bits_left_reg;
        tune_len_next   = tune_len_reg;
        tune_next       = tune_reg;
        mode_next       = mode_reg;
        phase_next      = phase_reg;
        enabled_next    = enabled_reg;
        beep_level_next = beep_level_reg;
        do_drive        = 1'b0;
        drive_level     = 1'b0;
        unique case (in_op_reg)
            OP_START: begin
                off_dur_next    = f_off;
                on_dur_next     = f_on;
                ticks_left_next = TIME_BITS'(1);
                bits_left_next  = tune_len_calc;
                tune_len_next   = tune_len_calc;
                tune_next       = f_tune;
                mode_next       = f_mode;
                phase_next      = {f_count, 1'b0};
                enabled_next    = (f_count != '0);
                do_drive        = (f_count == '0);
            end
            OP_TICK: begin
                if (enabled_reg && mode_reg != MODE_FOLLOW) begin
                    if (phase_reg == '0) begin
                        enabled_next = 1'b0;
                    end else begin
                        do_drive    = 1'b1;
                        drive_level = beep_level_reg;
                        if (ticks_left_reg != '0) begin
                            ticks_left_next = ticks_dec;
                            if (ticks_dec == '0) begin
                                if (bits_left_reg != '0) begin
                                    bits_left_next = bits_dec;
                                    drive_level    = tune_reg[bits_dec[TIDX_W-1:0]];
                                end else begin
                                    bits_left_next = tune_len_reg;
                                    drive_level    = phase_step[0];
                                    if (mode_reg != MODE_COUNTED) begin
                                        phase_next = phase_step | PHASE_W'(2);
                                    end else begin
                                        phase_next = phase_step;
                                    end
                                end
                                ticks_left_next = drive_level ? on_dur_reg : off_dur_reg;
                            end
                        end
                        beep_level_next = drive_level;
                    end
                end
            end
            OP_LED: begin
                if (enabled_reg && mode_reg == MODE_FOLLOW) begin
                    beep_level_next = f_led;
                    do_drive        = 1'b1;
                    drive_level     = f_led;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        out_level     = drive_level ^ invert_reg;
        res_kind      = DRIVE_NONE;
        res_pin       = 1'b0;
        res_duty      = '0;
        last_pwm_next = last_pwm_reg;
        if (do_drive) begin
            if (freq_mode_reg) begin
                if (last_pwm_reg != out_level) begin
                    res_kind      = DRIVE_PWM;
                    res_duty      = out_level ? (pwm_range_reg >> 1) : '0;
                    last_pwm_next = out_level;
                end
            end else begin
                res_kind = DRIVE_DIGITAL;
                res_pin  = out_level;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg    <= 1'b0;
            freq_mode_reg <= 1'b0;
            pwm_range_reg <= PWM_RANGE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_INVERT:    invert_reg    <= cfg_wdata[0];
                CFG_FREQ_MODE: freq_mode_reg <= cfg_wdata[0];
                CFG_PWM_RANGE: pwm_range_reg <= cfg_wdata[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_op_reg   <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {PAD_W'(0), enabled_next, res_duty, res_pin};
            out_kind_reg <= res_kind;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_dur_reg    <= '0;
            on_dur_reg     <= '0;
            ticks_left_reg <= '0;
            bits_left_reg  <= '0;
            tune_len_reg   <= '0;
            tune_reg       <= '0;
            mode_reg       <= MODE_COUNTED;
            phase_reg      <= '0;
            enabled_reg    <= 1'b0;
            beep_level_reg <= 1'b0;
            last_pwm_reg   <= 1'b0;
        end else if (advance) begin
            off_dur_reg    <= off_dur_next;
            on_dur_reg     <= on_dur_next;
            ticks_left_reg <= ticks_left_next;
            bits_left_reg  <= bits_left_next;
            tune_len_reg   <= tune_len_next;
            tune_reg       <= tune_next;
            mode_reg       <= mode_next;
            phase_reg      <= phase_next;
            enabled_reg    <= enabled_next;
            beep_level_reg <= beep_level_next;
            last_pwm_reg   <= last_pwm_next;
        end
    end

endmodule

// File: src/bps_checker.sv
`include "beep_pattern_sequencer_top_defines.svh"

module bps_checker
    import bps_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic [KIND_W-1:0]     m_tuser
);

    `BPS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Stalled result transfer changed or dropped.")

    `BPS_ASSERT_SAME(a_duty_only_pwm, aclk, aresetn, m_tvalid && m_tuser != DRIVE_PWM, m_tdata[DUTY_W:1] == '0, "Duty is nonzero without a PWM write.")

    `BPS_ASSERT_SAME(a_pin_only_digital, aclk, aresetn, m_tvalid && m_tuser != DRIVE_DIGITAL, m_tdata[0] == 1'b0, "Pin level is set without a digital write.")

    `BPS_ASSERT_SAME(a_kind_defined, aclk, aresetn, m_tvalid, m_tuser != DRIVE_RSVD, "Reserved drive kind on the result channel.")

endmodule

bind beep_pattern_sequencer_top bps_checker u_bps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
